// ===== design/ogon_pkg.sv =====
// Shared types and constants of the occupancy grid with open-neighbor queries.
// Word formats of both channels, sequencer states, operation codes and the
// neighbor direction table. No dependencies.
package ogon_pkg;

  localparam int unsigned MAX_COLS = 64;
  localparam int unsigned MAX_ROWS = 64;
  localparam int unsigned CELLS    = MAX_COLS * MAX_ROWS;
  localparam int unsigned ADDR_W   = $clog2(CELLS);

  // Coordinates are 6-bit fields; one sign bit and one carry bit on top.
  localparam int unsigned COORD_W  = 6;
  localparam int unsigned SCOORD_W = COORD_W + 2;
  localparam int unsigned REG_W    = 7;

  localparam logic [1:0] OP_SET       = 2'd0;
  localparam logic [1:0] OP_NEIGHBORS = 2'd1;

  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  localparam logic [3:0] LAST_STEP = 4'd8;

  typedef logic signed [1:0] delta_t;

  localparam delta_t DIR_DC [8] = '{2'sd0, 2'sd1, 2'sd0, -2'sd1, -2'sd1, 2'sd1, -2'sd1, 2'sd1};
  localparam delta_t DIR_DR [8] = '{-2'sd1, 2'sd0, 2'sd1, 2'sd0, -2'sd1, -2'sd1, 2'sd1, 2'sd1};

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               solid_value;
  } in_word_t;

  typedef struct packed {
    logic       in_range;
    logic       cell_solid;
    logic       cell_near_wall;
    logic       cell_open;
    logic [7:0] open_mask;
    logic [3:0] open_count;
  } out_word_t;

endpackage

// ===== design/occupancy_grid_open_neighbors.sv =====
// Top level of the occupancy grid: cell stores, walk sequencer, output register.
// Depends on ogon_pkg.
//
// Each accepted word walks the addressed cell and then its eight neighbors
// through one shared coordinate/bounds unit, one cell per cycle on a single
// port of the solid and near-wall stores. From accept to the next accept an
// item makes nine store accesses, then a drain state for the last registered
// read, a done state that builds the result, and idle. The result sits in an
// output register, so the next word is taken while it waits. After reset the
// block sweeps all 4096 cells of both stores to zero, one cell a cycle; input
// stays stalled during the sweep while configuration writes are taken.
module occupancy_grid_open_neighbors (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  ogon_pkg::in_word_t     in_word,
  output logic                   out_valid,
  input  logic                   out_stall,
  output ogon_pkg::out_word_t    out_word,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [ogon_pkg::REG_W-1:0] cfg_data
);
  import ogon_pkg::*;

  state_t state, state_next;

  logic [REG_W-1:0]  grid_width, grid_height;
  logic [REG_W-1:0]  eff_w, eff_h;

  logic [ADDR_W-1:0] clr_addr;
  logic [3:0]        step;
  in_word_t          item;
  logic              in_range;

  // tag of the read issued last cycle
  logic              pend_live, pend_center, pend_ok;
  logic [2:0]        pend_dir;

  logic              c_solid, c_near;
  logic [7:0]        mask;
  logic [3:0]        count;

  logic              solid_mem [CELLS];
  logic              near_mem  [CELLS];
  logic              solid_rd, near_rd;
  logic              solid_we, near_we, wr_data;
  logic [ADDR_W-1:0] mem_addr;

  logic [2:0]        dir;
  delta_t            dc, dr;
  logic [SCOORD_W-1:0] nc, nr;
  logic              nb_ok;
  logic              accept, load_out, is_set, nb_open;
  out_word_t         result;

  always_comb begin
    eff_w = (grid_width  > REG_W'(MAX_COLS)) ? REG_W'(MAX_COLS) : grid_width;
    eff_h = (grid_height > REG_W'(MAX_ROWS)) ? REG_W'(MAX_ROWS) : grid_height;
  end

  // shared neighbor coordinate and bounds unit
  always_comb begin
    dir = 3'(step - 4'd1);
    if (step == 4'd0) begin
      dc = 2'sd0;
      dr = 2'sd0;
    end else begin
      dc = DIR_DC[dir];
      dr = DIR_DR[dir];
    end
    nc = SCOORD_W'(item.col) + {{(SCOORD_W-2){dc[1]}}, dc};
    nr = SCOORD_W'(item.row) + {{(SCOORD_W-2){dr[1]}}, dr};
    nb_ok = !nc[SCOORD_W-1] && !nr[SCOORD_W-1]
            && (nc < SCOORD_W'(eff_w)) && (nr < SCOORD_W'(eff_h));
  end

  assign is_set  = (item.operation == OP_SET);
  assign accept  = in_valid && !in_stall;
  assign nb_open = pend_ok && !solid_rd && !near_rd;

  // sequencer
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    load_out   = 1'b0;
    solid_we   = 1'b0;
    near_we    = 1'b0;
    wr_data    = 1'b0;
    mem_addr   = clr_addr;
    unique case (state)
      ST_CLEAR: begin
        solid_we = 1'b1;
        near_we  = 1'b1;
        if (clr_addr == ADDR_W'(CELLS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) state_next = ST_WALK;
      end
      ST_WALK: begin
        mem_addr = ADDR_W'(nr[COORD_W-1:0]) * ADDR_W'(MAX_COLS)
                   + ADDR_W'(nc[COORD_W-1:0]);
        if (step == 4'd0) begin
          solid_we = is_set && in_range;
          wr_data  = item.solid_value;
        end else begin
          near_we  = is_set && item.solid_value && in_range && nb_ok;
          wr_data  = 1'b1;
        end
        if (step == LAST_STEP) state_next = ST_DRAIN;
      end
      ST_DRAIN: state_next = ST_DONE;
      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  // cell stores
  always_ff @(posedge clk) begin
    if (solid_we) solid_mem[mem_addr] <= wr_data;
    solid_rd <= solid_mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (near_we) near_mem[mem_addr] <= wr_data;
    near_rd <= near_mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= REG_W'(64);
      grid_height <= REG_W'(64);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:  grid_width  <= cfg_data;
        REG_GRID_HEIGHT: grid_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr  <= '0;
      step      <= '0;
      pend_live <= 1'b0;
    end else begin
      if (state == ST_CLEAR) clr_addr <= clr_addr + ADDR_W'(1);
      if (accept)                step <= '0;
      else if (state == ST_WALK) step <= step + 4'd1;
      pend_live <= (state == ST_WALK);
    end
  end

  always_ff @(posedge clk) begin
    pend_center <= (step == 4'd0);
    pend_dir    <= dir;
    pend_ok     <= nb_ok;
    if (accept) begin
      item     <= in_word;
      in_range <= (SCOORD_W'(in_word.col) < SCOORD_W'(eff_w))
                  && (SCOORD_W'(in_word.row) < SCOORD_W'(eff_h));
      mask     <= '0;
      count    <= '0;
    end else if (pend_live) begin
      if (pend_center) begin
        c_solid <= solid_rd;
        c_near  <= near_rd;
      end else if (item.operation == OP_NEIGHBORS && in_range && nb_open) begin
        mask[pend_dir] <= 1'b1;
        count          <= count + 4'd1;
      end
    end
  end

  always_comb begin
    result                = '0;
    if (in_range) begin
      result.in_range       = 1'b1;
      result.cell_solid     = is_set ? item.solid_value : c_solid;
      result.cell_near_wall = c_near;
      result.cell_open      = !result.cell_solid && !c_near;
      result.open_mask      = mask;
      result.open_count     = count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst)           out_valid <= 1'b0;
    else if (load_out) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load_out) out_word <= result;
  end

  a_count_matches_mask: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_word.open_count == 4'($countones(out_word.open_mask))))
    else $error("open_count disagrees with open_mask");

  a_out_of_range_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_word.in_range) |-> (out_word == '0))
    else $error("out-of-range result carries nonzero fields");

  a_writes_when_busy: assert property (@(posedge clk) disable iff (rst)
    (solid_we || near_we) |-> (state == ST_WALK || state == ST_CLEAR))
    else $error("store written outside walk or sweep");

  a_take_only_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_WALK && step == 4'd0))
    else $error("accepted word did not start a walk");

endmodule
